>>> hdl/nomm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nomm_pkg;

  // list sizes
  localparam int MAX_NEIGHBORS = 16;
  localparam int IDX_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

  // data widths
  localparam int COORD_W = 16;
  localparam int POINT_W = 2 * COORD_W;
  localparam int VEC_W = COORD_W + 1;
  localparam int COS_W = 16;
  localparam int SUM_W = COS_W + CNT_W;

  typedef enum logic [2:0] {
    CMD_SET_A   = 3'd0,
    CMD_ADD_A   = 3'd1,
    CMD_SET_B   = 3'd2,
    CMD_ADD_B   = 3'd3,
    CMD_COMPUTE = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // cosine unit request and response
  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] ax;
    logic signed [VEC_W-1:0] ay;
    logic signed [VEC_W-1:0] bx;
    logic signed [VEC_W-1:0] by;
  } cos_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [COS_W-1:0] cos;
  } cos_rsp_t;

endpackage

`default_nettype wire

>>> hdl/nomm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nomm_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [2:0]                              command;
  logic signed [nomm_pkg::COORD_W-1:0]     coord_x;
  logic signed [nomm_pkg::COORD_W-1:0]     coord_y;

  modport source (output valid, command, coord_x, coord_y, input ready);
  modport sink (input valid, command, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

>>> hdl/nomm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface nomm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [nomm_pkg::COS_W-1:0]   score;
  logic [4:0]                          mutual_count;
  logic                                overflowed;

  modport source (output valid, score, mutual_count, overflowed, input ready);
  modport sink (input valid, score, mutual_count, overflowed, output ready);
endinterface

`default_nettype wire

>>> hdl/nomm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nomm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/nomm_cos.sv
`timescale 1ns / 1ps
`default_nettype none

module nomm_cos (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nomm_pkg::cos_req_t  req_i,
  output nomm_pkg::cos_rsp_t       rsp_o
);

  localparam int VEC_W  = nomm_pkg::VEC_W;
  localparam int COS_W  = nomm_pkg::COS_W;
  localparam int NORM_W = 2 * VEC_W;
  localparam int SQ_W   = NORM_W + 16;
  localparam int RT_W   = SQ_W / 2;
  localparam int DEN_W  = 2 * RT_W;
  localparam int FRAC_W = 31;
  localparam int NUM_W  = NORM_W + FRAC_W;
  localparam int STEP_W = $clog2(NUM_W);
  localparam int Q_W    = 17;
  localparam logic [Q_W-1:0] Q_MAX = Q_W'(32'h10000);
  localparam logic [Q_W-1:0] POS_SAT = Q_W'(32'h7FFF);
  localparam logic [Q_W-1:0] NEG_SAT = Q_W'(32'h8000);

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MUL  = 6'b000010,
    C_SUM  = 6'b000100,
    C_SQRT = 6'b001000,
    C_PROD = 6'b010000,
    C_DIV  = 6'b100000
  } cstate_e;

  cstate_e state_q, state_d;
  logic done_q, done_d;
  logic signed [COS_W-1:0] cos_q, cos_d;
  logic signed [VEC_W-1:0] ax_q, ay_q, bx_q, by_q, ax_d, ay_d, bx_d, by_d;
  logic signed [NORM_W-1:0] pxx_q, pyy_q, paa_q, pab_q, pba_q, pbb_q;
  logic signed [NORM_W-1:0] pxx_d, pyy_d, paa_d, pab_d, pba_d, pbb_d;
  logic [SQ_W-1:0] opa_q, opb_q, resa_q, resb_q, opa_d, opb_d, resa_d, resb_d;
  logic [SQ_W-2:0] bit_q, bit_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d, rem_q, rem_d;
  logic [Q_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic neg_q, neg_d;

  // combinational helpers
  logic signed [NORM_W:0] dot_w, na_w, nb_w, mag_w;
  logic [SQ_W-1:0] tra_w, trb_w;
  logic [DEN_W:0] rsh_w;
  logic ge_w;
  logic [Q_W:0] qn_w;
  logic [Q_W-1:0] qneg_w;

  always_comb begin
    dot_w = (NORM_W+1)'(pxx_q) + (NORM_W+1)'(pyy_q);
    na_w = (NORM_W+1)'(paa_q) + (NORM_W+1)'(pab_q);
    nb_w = (NORM_W+1)'(pba_q) + (NORM_W+1)'(pbb_q);
    mag_w = dot_w[NORM_W] ? -dot_w : dot_w;
    tra_w = resa_q + SQ_W'(bit_q);
    trb_w = resb_q + SQ_W'(bit_q);
    rsh_w = {rem_q, num_q[NUM_W-1]};
    ge_w = rsh_w >= {1'b0, den_q};
    qn_w = {quo_q, ge_w};
  end

  // sequencer: products, norms, two square roots, one product, bit-serial divide; a zero norm ends early with zero
  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    cos_d = cos_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    pxx_d = pxx_q; pyy_d = pyy_q; paa_d = paa_q; pab_d = pab_q; pba_d = pba_q; pbb_d = pbb_q;
    opa_d = opa_q; opb_d = opb_q; resa_d = resa_q; resb_d = resb_q; bit_d = bit_q;
    num_d = num_q; den_d = den_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    neg_d = neg_q;
    qneg_w = '0;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          ax_d = req_i.ax; ay_d = req_i.ay; bx_d = req_i.bx; by_d = req_i.by;
          state_d = C_MUL;
        end
      end
      C_MUL: begin
        pxx_d = ax_q * bx_q;
        pyy_d = ay_q * by_q;
        paa_d = ax_q * ax_q;
        pab_d = ay_q * ay_q;
        pba_d = bx_q * bx_q;
        pbb_d = by_q * by_q;
        state_d = C_SUM;
      end
      C_SUM: begin
        if (na_w == '0 || nb_w == '0) begin
          cos_d = '0;
          done_d = 1'b1;
          state_d = C_IDLE;
        end else begin
          opa_d = {na_w[NORM_W-1:0], 16'b0};
          opb_d = {nb_w[NORM_W-1:0], 16'b0};
          resa_d = '0;
          resb_d = '0;
          bit_d = {1'b1, {(SQ_W-2){1'b0}}};
          num_d = {mag_w[NORM_W-1:0], {FRAC_W{1'b0}}};
          neg_d = dot_w[NORM_W];
          state_d = C_SQRT;
        end
      end
      C_SQRT: begin
        if (opa_q >= tra_w) begin
          opa_d = opa_q - tra_w;
          resa_d = (resa_q >> 1) + SQ_W'(bit_q);
        end else begin
          resa_d = resa_q >> 1;
        end
        if (opb_q >= trb_w) begin
          opb_d = opb_q - trb_w;
          resb_d = (resb_q >> 1) + SQ_W'(bit_q);
        end else begin
          resb_d = resb_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = C_PROD;
        end
      end
      C_PROD: begin
        den_d = resa_q[RT_W-1:0] * resb_q[RT_W-1:0];
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
        state_d = C_DIV;
      end
      C_DIV: begin
        rem_d = ge_w ? DEN_W'(rsh_w - {1'b0, den_q}) : rsh_w[DEN_W-1:0];
        quo_d = (qn_w > {1'b0, Q_MAX}) ? Q_MAX : qn_w[Q_W-1:0];
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(NUM_W - 1)) begin
          qneg_w = -quo_d;
          if (neg_q) begin
            cos_d = (quo_d >= NEG_SAT) ? NEG_SAT[COS_W-1:0] : qneg_w[COS_W-1:0];
          end else begin
            cos_d = (quo_d >= POS_SAT) ? POS_SAT[COS_W-1:0] : quo_d[COS_W-1:0];
          end
          done_d = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    pxx_q <= pxx_d; pyy_q <= pyy_d; paa_q <= paa_d; pab_q <= pab_d;
    pba_q <= pba_d; pbb_q <= pbb_d;
    opa_q <= opa_d; opb_q <= opb_d; resa_q <= resa_d; resb_q <= resb_d; bit_q <= bit_d;
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = (state_q != C_IDLE);
  assign rsp_o.done = done_q;
  assign rsp_o.cos = cos_q;

endmodule

`default_nettype wire

>>> hdl/neighbor_orientation_mutual_match.sv
// channel  dir  handshake      payload
// req_i    in   valid/ready    command, coord_x, coord_y
// rsp_o    out  valid/ready    score, mutual_count, overflowed
//
// load and clear requests give no response; only compute gives a response
// compute walks every neighbour pair through the cosine unit (bit-serial 65-step divide and
// 25-step square roots), then checks each A neighbour and divides the sum for the score
// req_i.ready is low while a compute runs; loads are taken while a response waits
// neighbour lists live in two 16-entry rams, one write and one read port each
// reset clears centres, counts and the drop flag; the lists need no clearing
`timescale 1ns / 1ps
`default_nettype none

module neighbor_orientation_mutual_match (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  nomm_req_if.sink       req_i,
  nomm_rsp_if.source     rsp_o
);

  localparam int MAXN  = nomm_pkg::MAX_NEIGHBORS;
  localparam int IDX_W = nomm_pkg::IDX_W;
  localparam int CNT_W = nomm_pkg::CNT_W;
  localparam int COS_W = nomm_pkg::COS_W;
  localparam int SUM_W = nomm_pkg::SUM_W;
  localparam int VEC_W = nomm_pkg::VEC_W;
  localparam int SC_W  = $clog2(SUM_W + 1);
  localparam logic [SUM_W-1:0] POS_SAT = SUM_W'(32'h7FFF);
  localparam logic [SUM_W-1:0] NEG_SAT = SUM_W'(32'h8000);

  typedef enum logic [7:0] {
    T_IDLE  = 8'b00000001,
    T_RD    = 8'b00000010,
    T_VEC   = 8'b00000100,
    T_WAIT  = 8'b00001000,
    T_FIN   = 8'b00010000,
    T_SINIT = 8'b00100000,
    T_SDIV  = 8'b01000000,
    T_DONE  = 8'b10000000
  } tstate_e;

  tstate_e state_q, state_d;
  nomm_pkg::point_t centre_a_q, centre_b_q;
  logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic drop_q;
  logic [IDX_W-1:0] i_q, j_q;
  logic signed [COS_W-1:0] rb_val_q;
  logic [IDX_W-1:0] rb_idx_q;
  logic signed [COS_W-1:0] row_val_q [MAXN];
  logic [IDX_W-1:0] row_idx_q [MAXN];
  logic signed [COS_W-1:0] col_val_q [MAXN];
  logic [IDX_W-1:0] col_idx_q [MAXN];
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] mutual_q;
  logic neg_q;
  logic [CNT_W-1:0] n_q;
  logic [SUM_W-1:0] snum_q, squo_q;
  logic [CNT_W-1:0] srem_q;
  logic [SC_W-1:0] scnt_q;
  logic out_valid_q;
  logic signed [COS_W-1:0] score_q;
  logic [4:0] mcount_q;
  logic ovf_q;

  logic req_fire, rsp_fire;
  nomm_pkg::cmd_e cmd;
  logic we_a, we_b;
  logic [nomm_pkg::POINT_W-1:0] wdata, rdata_a, rdata_b;
  nomm_pkg::point_t pa, pb;
  nomm_pkg::cos_req_t cos_req;
  nomm_pkg::cos_rsp_t cos_rsp;
  logic row_take, col_take, last_j, last_i, fin_hit, load_out;
  logic signed [COS_W-1:0] rb_val_d;
  logic [IDX_W-1:0] rb_idx_d;
  logic [CNT_W:0] srsh;
  logic sge;
  logic [SUM_W-1:0] smag, squo_neg;
  logic signed [COS_W-1:0] score_d;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign cmd = nomm_pkg::cmd_e'(req_i.command);
  assign req_i.ready = (state_q == T_IDLE);
  assign wdata = {req_i.coord_y, req_i.coord_x};

  assign we_a = req_fire && (cmd == nomm_pkg::CMD_ADD_A) && (cnt_a_q < CNT_W'(MAXN));
  assign we_b = req_fire && (cmd == nomm_pkg::CMD_ADD_B) && (cnt_b_q < CNT_W'(MAXN));

  // neighbour lists
  nomm_ram #(.WIDTH(nomm_pkg::POINT_W), .DEPTH(MAXN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (i_q),
    .rdata_o (rdata_a)
  );

  nomm_ram #(.WIDTH(nomm_pkg::POINT_W), .DEPTH(MAXN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .raddr_i (j_q),
    .rdata_o (rdata_b)
  );

  // centre-to-neighbour vectors
  assign pa = nomm_pkg::point_t'(rdata_a);
  assign pb = nomm_pkg::point_t'(rdata_b);
  assign cos_req.start = (state_q == T_VEC);
  assign cos_req.ax = VEC_W'(pa.x) - VEC_W'(centre_a_q.x);
  assign cos_req.ay = VEC_W'(pa.y) - VEC_W'(centre_a_q.y);
  assign cos_req.bx = VEC_W'(pb.x) - VEC_W'(centre_b_q.x);
  assign cos_req.by = VEC_W'(pb.y) - VEC_W'(centre_b_q.y);

  nomm_cos u_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cos_req),
    .rsp_o  (cos_rsp)
  );

  // running row and column best, ties keep the lower index
  always_comb begin
    row_take = (j_q == '0) || (cos_rsp.cos > rb_val_q);
    col_take = (i_q == '0) || (cos_rsp.cos > col_val_q[j_q]);
    rb_val_d = row_take ? cos_rsp.cos : rb_val_q;
    rb_idx_d = row_take ? j_q : rb_idx_q;
    last_j = (CNT_W'(j_q) + 1'b1) == cnt_b_q;
    last_i = (CNT_W'(i_q) + 1'b1) == cnt_a_q;
    fin_hit = (col_idx_q[row_idx_q[i_q]] == i_q);
  end

  // score divider step and output shaping
  always_comb begin
    srsh = {srem_q, snum_q[SUM_W-1]};
    sge = srsh >= {1'b0, n_q};
    smag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    squo_neg = -squo_q;
    if (neg_q) begin
      score_d = (squo_q >= NEG_SAT) ? NEG_SAT[COS_W-1:0] : squo_neg[COS_W-1:0];
    end else begin
      score_d = (squo_q >= POS_SAT) ? POS_SAT[COS_W-1:0] : squo_q[COS_W-1:0];
    end
    load_out = (state_q == T_DONE) && (!out_valid_q || rsp_o.ready);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (req_fire && cmd == nomm_pkg::CMD_COMPUTE) begin
          state_d = (cnt_a_q == '0 || cnt_b_q == '0) ? T_DONE : T_RD;
        end
      end
      T_RD: state_d = T_VEC;
      T_VEC: state_d = T_WAIT;
      T_WAIT: begin
        if (cos_rsp.done) begin
          state_d = (last_j && last_i) ? T_FIN : T_RD;
        end
      end
      T_FIN: begin
        if (last_i) begin
          state_d = T_SINIT;
        end
      end
      T_SINIT: state_d = T_SDIV;
      T_SDIV: begin
        if (scnt_q == SC_W'(SUM_W - 1)) begin
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        if (load_out) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      centre_a_q <= '0;
      centre_b_q <= '0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      drop_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire) begin
        case (cmd)
          nomm_pkg::CMD_SET_A: centre_a_q <= nomm_pkg::point_t'(wdata);
          nomm_pkg::CMD_SET_B: centre_b_q <= nomm_pkg::point_t'(wdata);
          nomm_pkg::CMD_ADD_A: begin
            if (we_a) cnt_a_q <= cnt_a_q + 1'b1;
            else drop_q <= 1'b1;
          end
          nomm_pkg::CMD_ADD_B: begin
            if (we_b) cnt_b_q <= cnt_b_q + 1'b1;
            else drop_q <= 1'b1;
          end
          nomm_pkg::CMD_CLEAR: begin
            cnt_a_q <= '0;
            cnt_b_q <= '0;
            drop_q <= 1'b0;
          end
          nomm_pkg::CMD_COMPUTE: begin
            i_q <= '0;
            j_q <= '0;
          end
          default: ;
        endcase
      end
      // pair walk: j inner, i outer
      if (state_q == T_WAIT && cos_rsp.done) begin
        if (last_j) begin
          j_q <= '0;
          i_q <= last_i ? '0 : i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      if (state_q == T_FIN) begin
        i_q <= i_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire && cmd == nomm_pkg::CMD_COMPUTE) begin
      sum_q <= '0;
      mutual_q <= '0;
      neg_q <= 1'b0;
      squo_q <= '0;
    end
    if (state_q == T_WAIT && cos_rsp.done) begin
      rb_val_q <= rb_val_d;
      rb_idx_q <= rb_idx_d;
      if (col_take) begin
        col_val_q[j_q] <= cos_rsp.cos;
        col_idx_q[j_q] <= i_q;
      end
      if (last_j) begin
        row_val_q[i_q] <= rb_val_d;
        row_idx_q[i_q] <= rb_idx_d;
      end
    end
    // mutual check per A neighbour
    if (state_q == T_FIN && fin_hit) begin
      sum_q <= sum_q + {{(SUM_W-COS_W){row_val_q[i_q][COS_W-1]}}, row_val_q[i_q]};
      mutual_q <= mutual_q + 1'b1;
    end
    // rounded divide by the larger count
    if (state_q == T_SINIT) begin
      n_q <= (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
      neg_q <= sum_q[SUM_W-1];
      snum_q <= smag + SUM_W'(((cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q) >> 1);
      srem_q <= '0;
      squo_q <= '0;
      scnt_q <= '0;
    end
    if (state_q == T_SDIV) begin
      srem_q <= sge ? CNT_W'(srsh - {1'b0, n_q}) : srsh[CNT_W-1:0];
      squo_q <= {squo_q[SUM_W-2:0], sge};
      snum_q <= snum_q << 1;
      scnt_q <= scnt_q + 1'b1;
    end
    if (load_out) begin
      score_q <= score_d;
      mcount_q <= 5'(mutual_q);
      ovf_q <= drop_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.score = score_q;
  assign rsp_o.mutual_count = mcount_q;
  assign rsp_o.overflowed = ovf_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= CNT_W'(MAXN) && cnt_b_q <= CNT_W'(MAXN))
    else $error("neighbour count beyond list size");

  a_cos_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cos_req.start |-> !cos_rsp.busy)
    else $error("cosine unit started while busy");

  a_cos_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cos_rsp.done |-> state_q == T_WAIT)
    else $error("cosine result outside pair walk");

  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_FIN |-> CNT_W'(row_idx_q[i_q]) < cnt_b_q)
    else $error("row best index beyond B count");
`endif

endmodule

`default_nettype wire
